/* sv/mihs_pkg.sv */
// ---------------------------------------------------------------------------
// mihs_pkg: shared types and constants for the multi-index Hamming search
// Band geometry, mode codes, controller/datapath interface structs.
// ---------------------------------------------------------------------------
package mihs_pkg;

  localparam int unsigned MAX_DOCS_DEF = 4096;

  localparam int unsigned BAND_COUNT   = 16;
  localparam int unsigned BAND_W       = 16;
  localparam int unsigned CODE_W       = BAND_COUNT * BAND_W;
  localparam int unsigned RADIUS_W     = 7;
  localparam int unsigned RADIUS_LIMIT = 64;
  localparam int unsigned MODE_W       = 2;

  localparam int unsigned PROBE_W   = 14;
  localparam int unsigned VISITED_W = 17;
  localparam int unsigned UNIQUE_W  = 13;
  localparam int unsigned ISUM_W    = 24;

  localparam int unsigned IN_DATA_W  = 264;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // cumulative binomial sums: CUM16[k] = sum of C(16,d) for d < k
  localparam logic [11:0] CUM16 [6] = '{12'd0, 12'd1, 12'd17, 12'd137, 12'd697, 12'd2517};

  typedef struct packed {
    logic append;
    logic clear;
    logic query_start;
    logic scan_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic pipe_busy;
    logic out_busy;
  } stat_t;

endpackage

/* sv/mihs_ram.sv */
// ---------------------------------------------------------------------------
// mihs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ---------------------------------------------------------------------------
module mihs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mihs_ctrl.sv */
// ---------------------------------------------------------------------------
// mihs_ctrl: sequencing state machine
// Takes items, issues append/clear/query commands, steps the scan, drains the
// pipeline and hands the result to the output register.
// ---------------------------------------------------------------------------
module mihs_ctrl
  import mihs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic              in_ready_o,
  input  stat_t             stat_i,
  output cmd_t              cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (in_mode_i)
            MODE_APPEND: cmd_o.append = 1'b1;
            MODE_CLEAR:  cmd_o.clear  = 1'b1;
            MODE_QUERY: begin
              cmd_o.query_start = 1'b1;
              state_d           = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.empty) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (!stat_i.out_busy) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/mihs_dp.sv */
// ---------------------------------------------------------------------------
// mihs_dp: code store, band compare pipeline and result accumulators
// Scan pipeline: RAM read -> sixteen band compares -> accumulate.
// ---------------------------------------------------------------------------
module mihs_dp
  import mihs_pkg::*;
#(
  parameter int unsigned MAX_DOCS = MAX_DOCS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [CODE_W-1:0]     code_i,
  input  logic [RADIUS_W-1:0]   radius_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PROBE_W-1:0]    probe_total_o,
  output logic [VISITED_W-1:0]  visited_total_o,
  output logic [UNIQUE_W-1:0]   unique_total_o,
  output logic [ISUM_W-1:0]     index_sum_o
);

  localparam int unsigned AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int unsigned CW = $clog2(MAX_DOCS + 1);

  function automatic logic [4:0] ones16(input logic [BAND_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < BAND_W; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  // store
  logic [CW-1:0]     count_q;
  logic              full;
  logic              wr_en;
  logic [CODE_W-1:0] rdata;

  // query and scan
  logic [CODE_W-1:0]  query_q;
  logic [2:0]         thr_q [BAND_COUNT];
  logic [PROBE_W-1:0] probe_q;
  logic [AW-1:0]      addr_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_idx_q;
  logic [BAND_COUNT-1:0] match_d, match_q;
  logic               m_vld_q;
  logic [AW-1:0]      m_idx_q;

  // accumulators
  logic [VISITED_W-1:0] visited_q;
  logic [UNIQUE_W-1:0]  unique_q;
  logic [ISUM_W-1:0]    isum_q;

  // probe count for the clamped radius
  logic [RADIUS_W-1:0] r_clamp;
  logic [2:0]          quot;
  logic [3:0]          rem;
  logic [PROBE_W-1:0]  probe_d;

  logic out_valid_q;

  assign full  = (count_q == CW'(MAX_DOCS));
  assign wr_en = cmd_i.append && !full;

  mihs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_DOCS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (code_i),
    .re_i    (cmd_i.scan_step),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign r_clamp = (radius_i > RADIUS_W'(RADIUS_LIMIT)) ? RADIUS_W'(RADIUS_LIMIT) : radius_i;
  assign quot    = r_clamp[6:4];
  assign rem     = r_clamp[3:0];
  // bands 0..rem probe quot+1 distances, the rest probe quot
  assign probe_d = (PROBE_W'(rem) + PROBE_W'(1)) * PROBE_W'(CUM16[quot + 3'd1])
                 + PROBE_W'(4'd15 - rem) * PROBE_W'(CUM16[quot]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      query_q <= code_i;
      probe_q <= probe_d;
      for (int b = 0; b < BAND_COUNT; b++) begin
        thr_q[b] <= quot + 3'((4'(b) <= rem) ? 1 : 0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.query_start) begin
      addr_q <= '0;
    end else if (cmd_i.scan_step) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // a band matches when its distance is below the number of probed distances
  always_comb begin
    for (int b = 0; b < BAND_COUNT; b++) begin
      match_d[b] = ones16(query_q[b*BAND_W +: BAND_W] ^ rdata[b*BAND_W +: BAND_W])
                   < {2'b00, thr_q[b]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      m_vld_q  <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    m_idx_q  <= rd_idx_q;
    match_q  <= match_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      unique_q  <= '0;
      isum_q    <= '0;
    end else if (cmd_i.query_start) begin
      visited_q <= '0;
      unique_q  <= '0;
      isum_q    <= '0;
    end else if (m_vld_q) begin
      visited_q <= visited_q + VISITED_W'(ones16(match_q));
      if (|match_q) begin
        unique_q <= unique_q + UNIQUE_W'(1);
        isum_q   <= isum_q + ISUM_W'(m_idx_q) + ISUM_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      probe_total_o   <= probe_q;
      visited_total_o <= visited_q;
      unique_total_o  <= unique_q;
      index_sum_o     <= isum_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.scan_last = ((CW'(addr_q) + CW'(1)) == count_q);
  assign stat_o.pipe_busy = rd_vld_q || m_vld_q;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  // accumulators must be final before the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_load |-> !rd_vld_q && !m_vld_q)
    else $error("result loaded while scan pipeline busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> m_vld_q)
    else $error("read data lost in compare stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_load |=> out_valid_q)
    else $error("result not presented after load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (CW'(addr_q) < count_q))
    else $error("scan read beyond stored documents");

endmodule

/* sv/multi_index_hamming_candidate_search_top.sv */
// ---------------------------------------------------------------------------
// multi_index_hamming_candidate_search_top: 256-bit code store with
// multi-index Hamming radius queries
// Appends document codes, clears the store, and answers radius queries with
// probe count, visited count, unique candidate count and index sum.
// ---------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)                          tuser
// s_axis    in   code_word0..3 [255:0], radius [262:256], pad [263]  mode [1:0]
// m_axis    out  probe_total [13:0], visited_total [30:14],          -
//                unique_total [43:31], index_sum [67:44], pad [71:68]
//
// Append, clear and unused modes are handled as the item is taken, without leaving idle.
// For a query, the store RAM has one read port and the scan reads one document
// per cycle through a three-stage pipeline; an empty store skips the scan.
// Reset empties the store at once; stored words need no clearing.
// A finished query waits in the output register; a new item is taken while it
// waits, but a second query result holds until the first is taken.
// ---------------------------------------------------------------------------
module multi_index_hamming_candidate_search_top
  import mihs_pkg::*;
#(
  parameter int unsigned MAX_DOCS = MAX_DOCS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // code_word0, code_word1, code_word2, code_word3, radius
  input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // probe_total, visited_total, unique_total, index_sum
);

  cmd_t                 cmd;
  stat_t                stat;
  logic [PROBE_W-1:0]   probe_total;
  logic [VISITED_W-1:0] visited_total;
  logic [UNIQUE_W-1:0]  unique_total;
  logic [ISUM_W-1:0]    index_sum;

  mihs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mihs_dp #(
    .MAX_DOCS (MAX_DOCS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .code_i          (s_axis_tdata[CODE_W-1:0]),
    .radius_i        (s_axis_tdata[CODE_W +: RADIUS_W]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .probe_total_o   (probe_total),
    .visited_total_o (visited_total),
    .unique_total_o  (unique_total),
    .index_sum_o     (index_sum)
  );

  assign m_axis_tdata = {4'b0000, index_sum, unique_total, visited_total, probe_total};

endmodule
